@@ hdl/abit_pkg.sv @@
// abit_pkg: shared types, constants and helpers of the alternating-bit sender
// used by abit_ctrl and alternating_bit_sender; no dependencies
package abit_pkg;

    // geometry of the message queue
    localparam int MESSAGE_BYTES  = 20;
    localparam int QUEUE_MESSAGES = 64;
    localparam int STORE_DEPTH    = MESSAGE_BYTES * QUEUE_MESSAGES;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int SLOT_W         = $clog2(QUEUE_MESSAGES);
    localparam int COUNT_W        = $clog2(QUEUE_MESSAGES + 1);
    localparam int POS_W          = $clog2(MESSAGE_BYTES + 1);

    // field widths
    localparam int BYTE_W   = 8;
    localparam int SUM_W    = 13;
    localparam int TIMER_W  = 16;
    localparam int ACKNUM_W = 16;

    // fixed packet values
    localparam logic [BYTE_W-1:0]  ACK_CONST     = 8'd123;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd10;

    // input command codes
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_EMIT
    } state_t;

    // result control from the sequencer to the output formatting
    typedef struct packed {
        logic strobe;
        logic kind;
        logic seq;
        logic last;
    } res_ctl_t;

    // first store address of a queue slot
    function automatic logic [STORE_AW-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        slot_base = STORE_AW'(slot) * STORE_AW'(MESSAGE_BYTES);
    endfunction

endpackage

@@ hdl/abit_ram.sv @@
// abit_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module abit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/abit_ctrl.sv @@
// abit_ctrl: request sequencer of the alternating-bit sender, queue pointers,
// timer and memory access; depends on abit_pkg
module abit_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [abit_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            last_byte,
    input  logic [abit_pkg::ACKNUM_W-1:0]   ack_number,
    input  logic [abit_pkg::TIMER_W-1:0]    timeout,
    // message store port
    output logic                            store_we,
    output logic [abit_pkg::STORE_AW-1:0]   store_waddr,
    output logic [abit_pkg::BYTE_W-1:0]     store_wdata,
    output logic                            store_re,
    output logic [abit_pkg::STORE_AW-1:0]   store_raddr,
    // message sum port
    output logic                            sums_we,
    output logic [abit_pkg::SLOT_W-1:0]     sums_waddr,
    output logic [abit_pkg::SUM_W-1:0]      sums_wdata,
    output logic                            sums_re,
    output logic [abit_pkg::SLOT_W-1:0]     sums_raddr,
    // result control
    output abit_pkg::res_ctl_t              res_ctl
);
    import abit_pkg::*;

    state_t               state_reg,      state_next;
    logic                 send_bit_reg,   send_bit_next;
    logic                 in_transit_reg, in_transit_next;
    logic [SLOT_W-1:0]    head_reg,       head_next;
    logic [SLOT_W-1:0]    tail_reg,       tail_next;
    logic [COUNT_W-1:0]   count_reg,      count_next;
    logic [POS_W-1:0]     fill_reg,       fill_next;
    logic                 zero_seen_reg,  zero_seen_next;
    logic                 dropping_reg,   dropping_next;
    logic [SUM_W-1:0]     sum_reg,        sum_next;
    logic [TIMER_W-1:0]   timer_reg,      timer_next;
    logic [POS_W-1:0]     pos_reg,        pos_next;
    logic [STORE_AW-1:0]  pad_addr_reg,   pad_addr_next;
    res_ctl_t             res_reg,        res_next;

    logic                 accept;
    logic                 drop_now;
    logic                 zero_now;
    logic [BYTE_W-1:0]    byte_val;
    logic [POS_W-1:0]     fill_inc;
    logic                 msg_end;
    logic [SUM_W-1:0]     sum_new;
    logic [TIMER_W-1:0]   timer_restart;
    logic [TIMER_W-1:0]   timer_dec;
    logic [COUNT_W-1:0]   count_dec;
    logic [SLOT_W-1:0]    tail_inc;
    logic [SLOT_W-1:0]    head_inc;
    logic                 pos_last;

    assign accept        = start && (state_reg == ST_IDLE);
    assign busy          = (state_reg != ST_IDLE);
    assign res_ctl       = res_reg;

    // byte path helpers
    assign drop_now      = (fill_reg == '0) ? (count_reg >= COUNT_W'(QUEUE_MESSAGES))
                                            : dropping_reg;
    assign zero_now      = zero_seen_reg || (data_byte == '0);
    assign byte_val      = zero_now ? '0 : data_byte;
    assign fill_inc      = fill_reg + 1'b1;
    assign msg_end       = last_byte || (fill_inc == POS_W'(MESSAGE_BYTES));
    assign sum_new       = sum_reg + SUM_W'(byte_val);

    // pointer and timer helpers
    assign timer_restart = (timeout == '0) ? TIMER_W'(1) : timeout;
    assign timer_dec     = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign count_dec     = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign tail_inc      = (tail_reg == SLOT_W'(QUEUE_MESSAGES - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc      = (head_reg == SLOT_W'(QUEUE_MESSAGES - 1)) ? '0 : head_reg + 1'b1;
    assign pos_last      = (pos_reg == POS_W'(MESSAGE_BYTES - 1));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            send_bit_reg   <= 1'b0;
            in_transit_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            fill_reg       <= '0;
            zero_seen_reg  <= 1'b0;
            dropping_reg   <= 1'b0;
            sum_reg        <= '0;
            timer_reg      <= '0;
            pos_reg        <= '0;
            pad_addr_reg   <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            send_bit_reg   <= send_bit_next;
            in_transit_reg <= in_transit_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            fill_reg       <= fill_next;
            zero_seen_reg  <= zero_seen_next;
            dropping_reg   <= dropping_next;
            sum_reg        <= sum_next;
            timer_reg      <= timer_next;
            pos_reg        <= pos_next;
            pad_addr_reg   <= pad_addr_next;
            res_reg        <= res_next;
        end
    end

    // next state, memory access and results
    always_comb
    begin
        state_next      = state_reg;
        send_bit_next   = send_bit_reg;
        in_transit_next = in_transit_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        zero_seen_next  = zero_seen_reg;
        dropping_next   = dropping_reg;
        sum_next        = sum_reg;
        timer_next      = timer_reg;
        pos_next        = pos_reg;
        pad_addr_next   = pad_addr_reg;
        res_next        = '0;

        store_we        = 1'b0;
        store_waddr     = slot_base(tail_reg) + STORE_AW'(fill_reg);
        store_wdata     = byte_val;
        store_re        = 1'b0;
        store_raddr     = slot_base(head_reg) + STORE_AW'(pos_reg);
        sums_we         = 1'b0;
        sums_waddr      = tail_reg;
        sums_wdata      = sum_new;
        sums_re         = 1'b0;
        sums_raddr      = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(command))
                        CMD_BYTE:
                        begin
                            store_we = !drop_now;
                            if (!msg_end)
                            begin
                                fill_next      = fill_inc;
                                zero_seen_next = zero_now;
                                dropping_next  = drop_now;
                                sum_next       = sum_new;
                            end
                            else
                            begin
                                fill_next      = '0;
                                zero_seen_next = 1'b0;
                                dropping_next  = 1'b0;
                                sum_next       = '0;
                                if (drop_now)
                                begin
                                    // queue was full: one drop result
                                    res_next.strobe = 1'b1;
                                    res_next.kind   = 1'b1;
                                    res_next.last   = 1'b1;
                                end
                                else
                                begin
                                    // commit the message to its slot
                                    sums_we    = 1'b1;
                                    tail_next  = tail_inc;
                                    count_next = count_reg + 1'b1;
                                    if (fill_inc != POS_W'(MESSAGE_BYTES))
                                    begin
                                        // short message: zero the rest first
                                        pos_next      = fill_inc;
                                        pad_addr_next = store_waddr + 1'b1;
                                        state_next    = ST_PAD;
                                    end
                                    else if (!in_transit_reg)
                                    begin
                                        pos_next        = '0;
                                        in_transit_next = 1'b1;
                                        timer_next      = timer_restart;
                                        state_next      = ST_EMIT;
                                    end
                                end
                            end
                        end
                        CMD_ACK:
                        begin
                            if (in_transit_reg && (ack_number == ACKNUM_W'(send_bit_reg)))
                            begin
                                send_bit_next   = !send_bit_reg;
                                timer_next      = '0;
                                in_transit_next = 1'b0;
                                head_next       = head_inc;
                                count_next      = count_dec;
                                if (count_dec != '0)
                                begin
                                    pos_next        = '0;
                                    in_transit_next = 1'b1;
                                    timer_next      = timer_restart;
                                    state_next      = ST_EMIT;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (in_transit_reg)
                            begin
                                timer_next = timer_dec;
                                if (timer_dec == '0)
                                begin
                                    pos_next   = '0;
                                    timer_next = timer_restart;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                // one zero byte a cycle up to the end of the slot
                store_we      = 1'b1;
                store_waddr   = pad_addr_reg;
                store_wdata   = '0;
                pad_addr_next = pad_addr_reg + 1'b1;
                pos_next      = pos_reg + 1'b1;
                if (pos_last)
                begin
                    if (in_transit_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next        = '0;
                        in_transit_next = 1'b1;
                        timer_next      = timer_restart;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // read one payload byte a cycle, sum with the first
                store_re        = 1'b1;
                sums_re         = (pos_reg == '0);
                res_next.strobe = 1'b1;
                res_next.kind   = 1'b0;
                res_next.seq    = send_bit_reg;
                res_next.last   = pos_last;
                pos_next        = pos_reg + 1'b1;
                if (pos_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/alternating_bit_sender.sv @@
// alternating_bit_sender: top level of the alternating-bit sender
// depends on abit_pkg, abit_ram and abit_ctrl
//
// A request is taken when start is high and busy is low. A message byte that
// does not end its message leaves busy low. A message end that leaves the slot
// short zeroes the rest of the slot at one byte per cycle; a packet send (on a
// completed message while idle, a matching ack with more queued, or a timer
// expiry) reads the message store at one byte per cycle and gives 20 results
// on consecutive cycles once any padding is done; busy stays high while the
// slot is padded and the store is read. Results come with result_strobe for a
// single cycle and cannot be held off. A drop result shows in the cycle right
// after its request is taken. The timeout register is written over
// cfg_valid/cfg_ready, and cfg_ready is only high while idle.
module alternating_bit_sender (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      command,
    input  logic [abit_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            last_byte,
    input  logic [abit_pkg::ACKNUM_W-1:0]   ack_number,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abit_pkg::TIMER_W-1:0]    timeout_ticks,
    // results
    output logic                            result_strobe,
    output logic                            kind,
    output logic                            seq_bit,
    output logic [abit_pkg::BYTE_W-1:0]     ack_field,
    output logic [abit_pkg::SUM_W-1:0]      checksum,
    output logic [abit_pkg::BYTE_W-1:0]     payload_byte,
    output logic                            last
);
    import abit_pkg::*;

    logic [TIMER_W-1:0]  timeout_reg;

    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [BYTE_W-1:0]   store_wdata;
    logic                store_re;
    logic [STORE_AW-1:0] store_raddr;
    logic [BYTE_W-1:0]   store_rdata;
    logic                sums_we;
    logic [SLOT_W-1:0]   sums_waddr;
    logic [SUM_W-1:0]    sums_wdata;
    logic                sums_re;
    logic [SLOT_W-1:0]   sums_raddr;
    logic [SUM_W-1:0]    sums_rdata;
    res_ctl_t            res_ctl;

    // timeout register
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= timeout_ticks;
        end
    end

    // message bytes
    abit_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // per-slot byte sums
    abit_ram #(
        .WIDTH (SUM_W),
        .DEPTH (QUEUE_MESSAGES)
    ) u_sums (
        .clk   (clk),
        .we    (sums_we),
        .waddr (sums_waddr),
        .wdata (sums_wdata),
        .re    (sums_re),
        .raddr (sums_raddr),
        .rdata (sums_rdata)
    );

    // sequencer
    abit_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .ack_number  (ack_number),
        .timeout     (timeout_reg),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .store_re    (store_re),
        .store_raddr (store_raddr),
        .sums_we     (sums_we),
        .sums_waddr  (sums_waddr),
        .sums_wdata  (sums_wdata),
        .sums_re     (sums_re),
        .sums_raddr  (sums_raddr),
        .res_ctl     (res_ctl)
    );

    // result formatting, drop results carry zeros
    assign result_strobe = res_ctl.strobe;
    assign kind          = res_ctl.kind;
    assign last          = res_ctl.last;
    assign seq_bit       = res_ctl.kind ? 1'b0 : res_ctl.seq;
    assign ack_field     = res_ctl.kind ? '0 : ACK_CONST;
    assign payload_byte  = res_ctl.kind ? '0 : store_rdata;
    assign checksum      = res_ctl.kind ? '0
                         : sums_rdata + SUM_W'(res_ctl.seq) + SUM_W'(ACK_CONST);

    // packet bytes only come out of a send sequence
    a_packet_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !kind) |-> $past(busy))
        else $error("packet byte without a send sequence");

    // a drop result answers a request taken in the cycle before
    a_drop_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && kind) |-> $past(start && !busy))
        else $error("drop result without a request");

    // a drop result is a run of its own
    a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && kind) |-> last)
        else $error("drop result not marked last");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking testbench of the alternating-bit sender
// depends on abit_pkg and alternating_bit_sender; predicts every packet byte and drop

module tb_top;

    import abit_pkg::*;

    // command code the block does not define
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam int  CLK_HALF      = 10;
    localparam int  RANDOM_ITEMS  = 30;
    localparam int  CFG_EVERY     = 10;
    localparam int  SETTLE_CYCLES = 45;
    localparam int  DRAIN_LIMIT   = 5000;
    localparam int  REPORT_LIMIT  = 10;
    localparam real WATCHDOG_NS   = 8.0e6;

    // one result of the block
    typedef struct {
        logic                kind;
        logic                seq;
        logic [BYTE_W-1:0]   ackf;
        logic [SUM_W-1:0]    csum;
        logic [BYTE_W-1:0]   pay;
        logic                fin;
    } tx_beat_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          command;
    logic [BYTE_W-1:0]   data_byte;
    logic                last_byte;
    logic [ACKNUM_W-1:0] ack_number;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TIMER_W-1:0]  timeout_ticks;
    logic                result_strobe;
    logic                kind;
    logic                seq_bit;
    logic [BYTE_W-1:0]   ack_field;
    logic [SUM_W-1:0]    checksum;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last;

    alternating_bit_sender DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .ack_number    (ack_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .timeout_ticks (timeout_ticks),
        .result_strobe (result_strobe),
        .kind          (kind),
        .seq_bit       (seq_bit),
        .ack_field     (ack_field),
        .checksum      (checksum),
        .payload_byte  (payload_byte),
        .last          (last)
    );

    // sender state as the testbench sees it
    logic [BYTE_W-1:0]  slot_bytes [QUEUE_MESSAGES][MESSAGE_BYTES];
    logic [SUM_W-1:0]   slot_sums [QUEUE_MESSAGES];
    logic               seq_now;
    bit                 in_flight;
    int unsigned        head_idx;
    int unsigned        tail_idx;
    int unsigned        held_msgs;
    int unsigned        fill_idx;
    bit                 zero_hit;
    bit                 discarding;
    int unsigned        ticks_left;
    logic [TIMER_W-1:0] retx_ticks;

    tx_beat_t beats_due[$];

    int fail_count;
    int useful_items;
    int burst_left;
    int gap_left;
    bit req_up;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("[alternating_bit_sender] ERROR");
        $finish;
    end

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endfunction

    function automatic void clear_sender_state();
        for (int s = 0; s < QUEUE_MESSAGES; s++)
        begin
            slot_sums[s] = '0;
            for (int b = 0; b < MESSAGE_BYTES; b++)
                slot_bytes[s][b] = '0;
        end
        seq_now    = 1'b0;
        in_flight  = 1'b0;
        head_idx   = 0;
        tail_idx   = 0;
        held_msgs  = 0;
        fill_idx   = 0;
        zero_hit   = 1'b0;
        discarding = 1'b0;
        ticks_left = 0;
        retx_ticks = TIMEOUT_RESET;
    endfunction

    // queue the 20 bytes of the head packet and rearm the timer
    function automatic void send_head_packet();
        tx_beat_t   b;
        logic [SUM_W-1:0] ck;
        ck = slot_sums[head_idx] + SUM_W'(seq_now) + SUM_W'(ACK_CONST);
        for (int k = 0; k < MESSAGE_BYTES; k++)
        begin
            b.kind = 1'b0;
            b.seq  = seq_now;
            b.ackf = ACK_CONST;
            b.csum = ck;
            b.pay  = slot_bytes[head_idx][k];
            b.fin  = (k == MESSAGE_BYTES - 1);
            beats_due.push_back(b);
        end
        in_flight  = 1'b1;
        ticks_left = (retx_ticks == 0) ? 1 : retx_ticks;
    endfunction

    // advance the sender by one request; acted is low when it is ignored
    function automatic void advance_sender(input logic [1:0] cmd,
                                           input logic [BYTE_W-1:0] dbyte,
                                           input logic lastb,
                                           input logic [ACKNUM_W-1:0] ackn,
                                           output bit acted);
        tx_beat_t b;
        int       sum;
        acted = 1'b1;
        case (cmd)
            CMD_BYTE:
            begin
                if (fill_idx == 0)
                    discarding = (held_msgs >= QUEUE_MESSAGES);
                if (dbyte == 0)
                    zero_hit = 1'b1;
                if (!discarding)
                    slot_bytes[tail_idx][fill_idx] = zero_hit ? '0 : dbyte;
                fill_idx++;
                if (lastb || fill_idx >= MESSAGE_BYTES)
                begin
                    if (discarding)
                    begin
                        b.kind = 1'b1;
                        b.seq  = 1'b0;
                        b.ackf = '0;
                        b.csum = '0;
                        b.pay  = '0;
                        b.fin  = 1'b1;
                        beats_due.push_back(b);
                    end
                    else
                    begin
                        sum = 0;
                        for (int k = 0; k < MESSAGE_BYTES; k++)
                        begin
                            if (k >= fill_idx)
                                slot_bytes[tail_idx][k] = '0;
                            sum += slot_bytes[tail_idx][k];
                        end
                        slot_sums[tail_idx] = SUM_W'(sum);
                        tail_idx = (tail_idx + 1) % QUEUE_MESSAGES;
                        held_msgs++;
                        if (!in_flight)
                            send_head_packet();
                    end
                    fill_idx   = 0;
                    zero_hit   = 1'b0;
                    discarding = 1'b0;
                end
            end
            CMD_ACK:
            begin
                if (!in_flight || ackn != {{(ACKNUM_W-1){1'b0}}, seq_now})
                    acted = 1'b0;
                else
                begin
                    seq_now    = ~seq_now;
                    ticks_left = 0;
                    in_flight  = 1'b0;
                    head_idx   = (head_idx + 1) % QUEUE_MESSAGES;
                    if (held_msgs > 0)
                        held_msgs--;
                    if (held_msgs > 0)
                        send_head_packet();
                end
            end
            CMD_TICK:
            begin
                if (!in_flight)
                    acted = 1'b0;
                else
                begin
                    if (ticks_left > 0)
                        ticks_left--;
                    if (ticks_left == 0)
                        send_head_packet();
                end
            end
            default:
                acted = 1'b0;
        endcase
    endfunction

    // result checker: every strobe is matched against the oldest expectation
    always @(posedge clk)
    begin : beat_check
        tx_beat_t want;
        if (rst_n && result_strobe)
        begin
            if (beats_due.size() == 0)
                note_failure($sformatf({"unexpected result kind=%0d seq=%0d ack=%0d",
                                        " sum=%0d byte=%0d last=%0d"},
                                       kind, seq_bit, ack_field, checksum,
                                       payload_byte, last));
            else
            begin
                want = beats_due.pop_front();
                if (kind !== want.kind || seq_bit !== want.seq ||
                    ack_field !== want.ackf || checksum !== want.csum ||
                    payload_byte !== want.pay || last !== want.fin)
                    note_failure($sformatf({"result mismatch exp kind=%0d seq=%0d ack=%0d",
                                            " sum=%0d byte=%0d last=%0d",
                                            " got kind=%0d seq=%0d ack=%0d",
                                            " sum=%0d byte=%0d last=%0d"},
                                           want.kind, want.seq, want.ackf, want.csum,
                                           want.pay, want.fin,
                                           kind, seq_bit, ack_field, checksum,
                                           payload_byte, last));
            end
        end
    end

    // drive one request, wait for it to be taken, then predict it
    task automatic send_request(input logic [1:0] cmd, input logic [BYTE_W-1:0] dbyte,
                                input logic lastb, input logic [ACKNUM_W-1:0] ackn);
        bit acted;
        int gap;
        if (gap_left > 0)
        begin
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        start      <= 1'b1;
        command    <= cmd;
        data_byte  <= dbyte;
        last_byte  <= lastb;
        ack_number <= ackn;
        req_up = 1'b1;
        do
            @(posedge clk);
        while (busy);
        advance_sender(cmd, dbyte, lastb, ackn, acted);
        if (acted)
            useful_items++;
        // bursts of random length, random gaps, some long bursts with no gap
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                start <= 1'b0;
                req_up = 1'b0;
                gap_left = gap;
            end
        end
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        return ($urandom_range(0, 9) == 0) ? '0 : BYTE_W'($urandom_range(1, 255));
    endfunction

    // one message of len bytes; close_it marks the end on the final byte, a full-length one only at random
    task automatic send_message(input int len, input bit close_it);
        logic lastb;
        for (int k = 0; k < len; k++)
        begin
            lastb = close_it && (k == len - 1) &&
                    (len < MESSAGE_BYTES || $urandom_range(0, 1) == 1);
            send_request(CMD_BYTE, rand_byte(), lastb, ACKNUM_W'($urandom));
        end
    endtask

    // stop sending and let every expected result come out
    task automatic settle_sender();
        int waited;
        if (req_up)
        begin
            start <= 1'b0;
            req_up = 1'b0;
        end
        gap_left = 0;
        waited = 0;
        while (beats_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (beats_due.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never came", beats_due.size()));
            beats_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMER_W-1:0] ticks);
        settle_sender();
        cfg_valid     <= 1'b1;
        timeout_ticks <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        retx_ticks = ticks;
    endtask

    // reserved command, acks and ticks while nothing is in transit
    task automatic test_ignored_inputs();
        send_request(CMD_RESERVED, 8'hFF, 1'b1, 16'hFFFF);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
    endtask

    // full-length message of 0xFF ended by byte count, then wrong and right acks
    task automatic test_full_message();
        for (int k = 0; k < MESSAGE_BYTES; k++)
            send_request(CMD_BYTE, 8'hFF, 1'b0, 16'h0000);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'hFFFF);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'h0001);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'h0000);
    endtask

    // bytes after a zero, short messages padded, next message sent on ack
    task automatic test_zero_padding();
        send_request(CMD_BYTE, 8'h80, 1'b0, 16'h0000);
        send_request(CMD_BYTE, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_BYTE, 8'h7F, 1'b1, 16'h0000);
        send_request(CMD_BYTE, 8'h00, 1'b1, 16'h0000);
        send_request(CMD_BYTE, 8'h01, 1'b1, 16'h0000);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'h0001);
        send_request(CMD_ACK, 8'h00, 1'b0, 16'h0000);
    endtask

    // retransmit on expiry at the timeout extremes, zero acting as one tick
    task automatic test_timer_expiry();
        write_timeout(16'd1);
        while (ticks_left > 1)
            send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        write_timeout(16'd0);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        write_timeout(16'd2);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        write_timeout(16'hFFFF);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_TICK, 8'h00, 1'b0, 16'h0000);
        send_request(CMD_ACK, 8'h00, 1'b0, {15'd0, seq_now});
    endtask

    // fill every slot, check drops, then drain the queue with acks
    task automatic test_queue_full();
        write_timeout(16'd3);
        while (held_msgs < QUEUE_MESSAGES)
            send_message(1, 1'b1);
        send_message(1, 1'b1);
        send_message(MESSAGE_BYTES, 1'b1);
        // the drop is decided at the first byte, even if a slot frees meanwhile
        send_message(2, 1'b0);
        send_request(CMD_ACK, rand_byte(), 1'b0, {15'd0, seq_now});
        send_message(1, 1'b1);
        send_message(2, 1'b1);
        while (held_msgs > 0)
            send_request(CMD_ACK, rand_byte(), 1'($urandom_range(0, 1)), {15'd0, seq_now});
    endtask

    // mostly well-formed traffic with random content, plus noise
    task automatic test_random_traffic();
        int                  pick;
        int                  run;
        int                  len;
        int                  goal;
        int                  next_cfg;
        logic [TIMER_W-1:0]  ticks;
        logic [ACKNUM_W-1:0] ackn;
        write_timeout(TIMEOUT_RESET);
        goal     = useful_items + RANDOM_ITEMS;
        next_cfg = useful_items + CFG_EVERY;
        while (useful_items < goal)
        begin
            // new timeout setting between phases
            if (useful_items >= next_cfg)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    ticks = 16'd0;
                else if (pick == 1)
                    ticks = 16'hFFFF;
                else if (pick < 4)
                    ticks = 16'd1;
                else
                    ticks = TIMER_W'($urandom_range(2, 12));
                write_timeout(ticks);
                next_cfg = useful_items + CFG_EVERY;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                len = $urandom_range(0, 9);
                if (len < 7)
                    len = $urandom_range(1, 6);
                else if (len < 9)
                    len = $urandom_range(7, MESSAGE_BYTES - 1);
                else
                    len = MESSAGE_BYTES;
                send_message(len, 1'b1);
            end
            else if (pick < 40)
                send_message($urandom_range(1, 5), 1'b0);
            else if (pick < 70)
            begin
                if (in_flight && $urandom_range(0, 4) != 0)
                    ackn = {15'd0, seq_now};
                else
                    ackn = ACKNUM_W'($urandom);
                send_request(CMD_ACK, rand_byte(), 1'($urandom_range(0, 1)), ackn);
            end
            else if (pick < 88)
            begin
                run = (retx_ticks == 0) ? 2 : ((retx_ticks > 12) ? 12 : retx_ticks + 1);
                run = $urandom_range(1, run);
                repeat (run)
                    send_request(CMD_TICK, rand_byte(), 1'($urandom_range(0, 1)),
                                 ACKNUM_W'($urandom));
            end
            else if (pick < 93)
                send_request(CMD_RESERVED, rand_byte(), 1'($urandom_range(0, 1)),
                             ACKNUM_W'($urandom));
            else if (pick < 95)
                settle_sender();
            else
                send_request(CMD_ACK, rand_byte(), 1'($urandom_range(0, 1)),
                             {15'd0, ~seq_now});
        end
    endtask

    // test sequence
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = CMD_BYTE;
        data_byte     = '0;
        last_byte     = 1'b0;
        ack_number    = '0;
        cfg_valid     = 1'b0;
        timeout_ticks = TIMEOUT_RESET;
        fail_count    = 0;
        useful_items  = 0;
        burst_left    = 0;
        gap_left      = 0;
        req_up        = 1'b0;
        clear_sender_state();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_inputs();
        test_full_message();
        test_zero_padding();
        test_timer_expiry();
        test_queue_full();
        test_random_traffic();

        settle_sender();
        if (fail_count == 0)
            $display("[alternating_bit_sender] OK");
        else
            $display("[alternating_bit_sender] ERROR");
        $finish;
    end

endmodule
